>>> rtl/prmm_pkg.sv
// Shared constants, codes and types of the prefix range min/max query block.
`default_nettype none
package prmm_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int VALUE_BITS   = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int ADDR_W       = IDX_W + 1;
   localparam int WALK_W       = ADDR_W + 1;
   localparam int DATA_W       = 44;
   localparam int NODE_W       = 2 * DATA_W;
   localparam int ANSWER_W     = 42;
   localparam int TREE_DEPTH   = 2 * MAX_ELEMENTS;

   localparam logic [DATA_W-1:0] TREE_HIGH = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] TREE_LOW  = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_UNBAL = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   typedef struct packed {
      logic              valid;
      logic              is_query;
      logic [IDX_W-1:0]  index;
      logic [IDX_W-1:0]  left;
      logic [IDX_W-1:0]  right;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  count;
   } prmm_cmd_type;

   typedef struct packed {
      logic                valid;
      logic [1:0]          status;
      logic [ANSWER_W-1:0] answer;
   } prmm_res_type;

endpackage
`default_nettype wire

>>> rtl/prmm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module prmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/prmm_engine.sv
// Tree update and range walk over the combined min/max node memory.
`default_nettype none
module prmm_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire prmm_pkg::prmm_cmd_type cmd,
   output      logic                  idle,
   output      prmm_pkg::prmm_res_type res,
   input  wire logic                  res_ack
);
   import prmm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_QBASE  = 6'b000100,
      ST_QWALK  = 6'b001000,
      ST_QEVAL  = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      TAG_NONE  = 2'd0,
      TAG_RIGHT = 2'd1,
      TAG_BASE  = 2'd2,
      TAG_NODE  = 2'd3
   } tag_type;

   state_type state_ff, state_in;
   tag_type   tag_ff, tag_in;

   logic [ADDR_W-1:0] node_ff, node_in;
   logic signed [DATA_W-1:0] cur_min_ff, cur_min_in, cur_max_ff, cur_max_in;
   logic [WALK_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]  left_ff, left_in;
   logic signed [DATA_W-1:0] base_ff, base_in, right_ff, right_in;
   logic [1:0]          status_ff, status_in;
   logic [ANSWER_W-1:0] answer_ff, answer_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr, parent;
   logic [NODE_W-1:0] wr_data, rd_data;
   logic signed [DATA_W-1:0] rd_min, rd_max, new_min, new_max, min_rel, max_rel;
   logic [WALK_W-1:0] hi_dec;

   prmm_ram #(.WIDTH(NODE_W), .DEPTH(TREE_DEPTH)) u_tree (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_min = rd_data[NODE_W-1:DATA_W];
   assign rd_max = rd_data[DATA_W-1:0];

   always_comb begin
      state_in   = state_ff;
      tag_in     = TAG_NONE;
      node_in    = node_ff;
      cur_min_in = cur_min_ff;
      cur_max_in = cur_max_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      left_in    = left_ff;
      base_in    = base_ff;
      right_in   = right_ff;
      status_in  = status_ff;
      answer_in  = answer_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_data    = {cur_min_ff, cur_max_ff};
      rd_addr    = node_ff ^ ADDR_W'(1);
      parent     = node_ff >> 1;
      hi_dec     = hi_ff - WALK_W'(1);
      new_min    = (rd_min < cur_min_ff) ? rd_min : cur_min_ff;
      new_max    = (rd_max > cur_max_ff) ? rd_max : cur_max_ff;
      min_rel    = cur_min_ff - base_ff;
      max_rel    = cur_max_ff - base_ff;

      // fold returned read data by its tag (query only)
      if (!state_ff[0] && !state_ff[1]) begin
         case (tag_ff)
            TAG_RIGHT: right_in = rd_max;
            TAG_BASE:  base_in  = rd_max;
            TAG_NODE: begin
               cur_min_in = new_min;
               cur_max_in = new_max;
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd.valid && !cmd.is_query) begin
               // write the leaf, fetch its sibling
               wr_en      = 1'b1;
               wr_addr    = {1'b1, cmd.index};
               wr_data    = {cmd.value, cmd.value};
               rd_addr    = {1'b1, cmd.index} ^ ADDR_W'(1);
               node_in    = {1'b1, cmd.index};
               cur_min_in = cmd.value;
               cur_max_in = cmd.value;
               state_in   = ST_LOAD;
            end else if (cmd.valid) begin
               if (cmd.right < cmd.left || CNT_W'(cmd.right) >= cmd.count) begin
                  status_in = STATUS_BAD;
                  answer_in = '0;
                  state_in  = ST_RESULT;
               end else begin
                  rd_addr    = {1'b1, cmd.right};
                  tag_in     = TAG_RIGHT;
                  left_in    = cmd.left;
                  base_in    = '0;
                  lo_in      = {2'b01, cmd.left};
                  hi_in      = {2'b01, cmd.right} + WALK_W'(1);
                  cur_min_in = TREE_HIGH;
                  cur_max_in = TREE_LOW;
                  state_in   = ST_QBASE;
               end
            end
         end
         ST_LOAD: begin
            wr_en      = 1'b1;
            wr_addr    = parent;
            wr_data    = {new_min, new_max};
            rd_addr    = parent ^ ADDR_W'(1);
            node_in    = parent;
            cur_min_in = new_min;
            cur_max_in = new_max;
            if (parent == ADDR_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QBASE: begin
            rd_addr = {1'b1, left_ff - IDX_W'(1)};
            if (left_ff != '0) begin
               tag_in = TAG_BASE;
            end
            state_in = ST_QWALK;
         end
         ST_QWALK: begin
            if (lo_ff < hi_ff) begin
               if (lo_ff[0]) begin
                  rd_addr = lo_ff[ADDR_W-1:0];
                  tag_in  = TAG_NODE;
                  lo_in   = lo_ff + WALK_W'(1);
               end else if (hi_ff[0]) begin
                  rd_addr = hi_dec[ADDR_W-1:0];
                  tag_in  = TAG_NODE;
                  hi_in   = hi_dec;
               end else begin
                  lo_in = lo_ff >> 1;
                  hi_in = hi_ff >> 1;
               end
            end else begin
               state_in = ST_QEVAL;
            end
         end
         ST_QEVAL: begin
            if (right_ff != base_ff || min_rel < 0) begin
               status_in = STATUS_UNBAL;
               answer_in = '0;
            end else begin
               status_in = STATUS_OK;
               answer_in = max_rel[ANSWER_W-1:0];
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tag_ff   <= TAG_NONE;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
      end
      node_ff    <= node_in;
      cur_min_ff <= cur_min_in;
      cur_max_ff <= cur_max_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      left_ff    <= left_in;
      base_ff    <= base_in;
      right_ff   <= right_in;
      status_ff  <= status_in;
      answer_ff  <= answer_in;
   end

   assign idle       = (state_ff == ST_IDLE);
   assign res.valid  = (state_ff == ST_RESULT);
   assign res.status = status_ff;
   assign res.answer = answer_ff;

endmodule
`default_nettype wire

>>> rtl/prefix_range_min_max_query.sv
// Top level: item channels, load count and running prefix sum, result register.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    mode, value_a, value_b, left/right_index
//   rsp_      out        rsp_valid/rsp_ready    status, answer
//
// Load: one tree level per cycle through the single node memory.
// Query: at most one node read per step of the range walk; a bad range skips
// the walk. Clear and ignored items do not occupy the engine.
// Synchronous reset empties the load; the node memory needs no clearing pass.
// A result waits in the output register while the next item is taken.
`default_nettype none
module prefix_range_min_max_query (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [1:0]                      req_mode,
   input  wire logic [31:0]                     req_value_a,
   input  wire logic [31:0]                     req_value_b,
   input  wire logic [prmm_pkg::IDX_W-1:0]      req_left_index,
   input  wire logic [prmm_pkg::IDX_W-1:0]      req_right_index,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [1:0]                      rsp_status,
   output      logic [prmm_pkg::ANSWER_W-1:0]   rsp_answer
);
   import prmm_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] sum_ff, sum_in, next_sum;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ANSWER_W-1:0] rsp_answer_ff, rsp_answer_in;
   logic              eng_idle, accept, full, res_ack;
   prmm_cmd_type      cmd;
   prmm_res_type      res;

   prmm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .idle   (eng_idle),
      .res    (res),
      .res_ack(res_ack)
   );

   always_comb begin
      req_ready = eng_idle;
      accept    = req_valid && eng_idle;
      full      = (count_ff == CNT_W'(MAX_ELEMENTS));
      next_sum  = sum_ff + DATA_W'(req_value_b[VALUE_BITS-1:0])
                         - DATA_W'(req_value_a[VALUE_BITS-1:0]);
      count_in  = count_ff;
      sum_in    = sum_ff;

      cmd.valid    = 1'b0;
      cmd.is_query = (req_mode == MODE_QUERY);
      cmd.index    = count_ff[IDX_W-1:0];
      cmd.left     = req_left_index;
      cmd.right    = req_right_index;
      cmd.value    = next_sum;
      cmd.count    = count_ff;

      if (accept) begin
         case (req_mode)
            MODE_LOAD: begin
               if (!full) begin
                  cmd.valid = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  sum_in    = next_sum;
               end
            end
            MODE_QUERY: cmd.valid = 1'b1;
            MODE_CLEAR: begin
               count_in = '0;
               sum_in   = '0;
            end
            default: ;
         endcase
      end

      // hold the result until the output register frees up
      res_ack       = res.valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_answer_in = rsp_answer_ff;
      if (res_ack) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res.status;
         rsp_answer_in = res.answer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_answer = rsp_answer_ff;

endmodule
`default_nettype wire

>>> tb/tb_prefix_range_min_max_query.sv
// Self-checking testbench for the prefix range min/max query block.
`default_nettype none
module tb_prefix_range_min_max_query;
   timeunit 1ns;
   timeprecision 1ps;
   import prmm_pkg::*;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] a;
      logic [31:0] b;
      logic [9:0]  l;
      logic [9:0]  r;
   } req_item_type;

   typedef struct {
      logic [1:0]          status;
      logic [ANSWER_W-1:0] answer;
   } rsp_item_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_value_a = '0;
   logic [31:0] req_value_b = '0;
   logic [9:0]  req_left_index = '0;
   logic [9:0]  req_right_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [ANSWER_W-1:0] rsp_answer;

   prefix_range_min_max_query u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_value_a(req_value_a), .req_value_b(req_value_b),
      .req_left_index(req_left_index), .req_right_index(req_right_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_answer(rsp_answer)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   int unsigned       pred_count;
   logic signed [43:0] pred_sum;
   logic signed [43:0] pred_prefix [MAX_ELEMENTS];

   req_item_type pending_q[$];
   rsp_item_type answer_q[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_cycles = 0;
   int  mismatches = 0;
   int  results_seen = 0;
   int  queries_sent = 0;
   int  loads_sent = 0;
   int  idle_cycles = 0;
   bit  req_ready_seen = 1'b0;

   // Range scan over the prefixes; same outcome as the tree walk.
   function automatic void predict_item(req_item_type it);
      rsp_item_type       res;
      logic signed [43:0] base;
      logic signed [43:0] mn;
      logic signed [43:0] mx;
      logic signed [43:0] d;
      if (it.mode == MODE_LOAD) begin
         if (pred_count < MAX_ELEMENTS) begin
            d = $signed({12'd0, it.b}) - $signed({12'd0, it.a});
            pred_sum = pred_sum + d;
            pred_prefix[pred_count] = pred_sum;
            pred_count++;
         end
      end else if (it.mode == MODE_CLEAR) begin
         pred_count = 0;
         pred_sum = '0;
      end else if (it.mode == MODE_QUERY) begin
         res.status = STATUS_BAD;
         res.answer = '0;
         if (!(it.r < it.l || it.r >= pred_count)) begin
            base = (it.l == 0) ? 44'sd0 : pred_prefix[it.l - 1];
            mn = pred_prefix[it.l];
            mx = pred_prefix[it.l];
            for (int i = it.l; i <= it.r; i++) begin
               if (pred_prefix[i] < mn) mn = pred_prefix[i];
               if (pred_prefix[i] > mx) mx = pred_prefix[i];
            end
            if (pred_prefix[it.r] != base || (mn - base) < 0) begin
               res.status = STATUS_UNBAL;
            end else begin
               res.status = STATUS_OK;
               d = mx - base;
               res.answer = d[ANSWER_W-1:0];
            end
         end
         answer_q.push_back(res);
      end
   endfunction

   function automatic req_item_type mk(logic [1:0] m, logic [31:0] a, logic [31:0] b,
                                       logic [9:0] l, logic [9:0] r);
      req_item_type it;
      it.mode = m; it.a = a; it.b = b; it.l = l; it.r = r;
      return it;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_item_type it;
               it = pending_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= it.mode;
               req_value_a <= it.a;
               req_value_b <= it.b;
               req_left_index <= it.l;
               req_right_index <= it.r;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      req_ready_seen <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_item_type it;
            it = mk(req_mode, req_value_a, req_value_b, req_left_index, req_right_index);
            predict_item(it);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d answer %0h", rsp_status, rsp_answer);
            end else begin
               rsp_item_type e;
               e = answer_q.pop_front();
               if (e.status !== rsp_status || e.answer !== rsp_answer) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected status %0d answer %0h, got %0d %0h",
                              e.status, e.answer, rsp_status, rsp_answer);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_cycles > 0)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", answer_q.size());
         $display("tb_prefix_range_min_max_query: done, errors");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_q.size() > 0 || req_valid || answer_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // queue a run of loads that climbs and falls back to its starting level
   task automatic queue_balanced(int n, int unsigned span);
      int unsigned lvl;
      int unsigned up;
      lvl = 0;
      for (int i = 0; i < n; i++) begin
         if (i == n - 1 || (lvl > 0 && $urandom_range(1))) begin
            up = (i == n - 1) ? lvl : $urandom_range(lvl);
            pending_q.push_back(mk(MODE_LOAD, up, 0, 0, 0));
            lvl -= up;
         end else begin
            up = $urandom_range(span);
            pending_q.push_back(mk(MODE_LOAD, 0, up, 0, 0));
            lvl += up;
         end
      end
      loads_sent += n;
   endtask

   task automatic queue_queries(int n, int unsigned cnt);
      int unsigned l;
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         if (cnt > 0 && $urandom_range(9) < 8) begin
            l = $urandom_range(cnt - 1);
            r = $urandom_range(cnt - 1, l);
            if ($urandom_range(2) == 0) l = 0;
            if ($urandom_range(2) == 0) r = cnt - 1;
         end else begin
            l = $urandom_range(1023);
            r = $urandom_range(1023);
         end
         pending_q.push_back(mk(MODE_QUERY, $urandom, $urandom, 10'(l), 10'(r)));
         queries_sent++;
      end
   endtask

   task automatic random_phase(int items);
      int done;
      int unsigned n;
      int unsigned cnt;
      done = 0;
      while (done < items) begin
         pending_q.push_back(mk(MODE_CLEAR, $urandom, $urandom, 10'($urandom),
                                10'($urandom)));
         n = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(12, 1);
         cnt = n;
         if ($urandom_range(3) == 0) begin
            for (int i = 0; i < n; i++)
               pending_q.push_back(mk(MODE_LOAD, $urandom, $urandom, 0, 0));
            loads_sent += n;
         end else begin
            queue_balanced(n, $urandom_range(1) ? 5 : 32'hffff_ffff);
         end
         if ($urandom_range(7) == 0)
            pending_q.push_back(mk(MODE_UNUSED, $urandom, $urandom, 10'($urandom),
                                   10'($urandom)));
         queue_queries(n / 2 + 2, cnt);
         done += n + n / 2 + 3;
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_ELEMENTS; i++) pred_prefix[i] = '0;
      pred_count = 0;
      pred_sum = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every mode, bad ranges, unbalanced
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 0, 0));
      pending_q.push_back(mk(MODE_LOAD, 0, 32'hffff_ffff, 0, 0));
      pending_q.push_back(mk(MODE_LOAD, 32'hffff_ffff, 0, 0, 0));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 0, 1));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 1, 1));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 1, 0));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 0, 2));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 10'h3ff, 10'h3ff));
      pending_q.push_back(mk(MODE_LOAD, 32'hffff_ffff, 0, 0, 0));
      pending_q.push_back(mk(MODE_LOAD, 0, 32'hffff_ffff, 0, 0));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 2, 3));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 0, 3));
      pending_q.push_back(mk(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff, 10'h3ff));
      pending_q.push_back(mk(MODE_CLEAR, 0, 0, 0, 0));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 0, 0));
      queries_sent += 9;
      loads_sent += 4;
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 0, 10'h3ff));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 10'h3ff, 10'h3ff));
      pending_q.push_back(mk(MODE_QUERY, 0, 0, 1, 10'h3fe));
      queries_sent += 3;
      wait_drained();

      // long receiver hold-off while items keep coming
      random_phase(60);
      hold_cycles <= 600;
      wait_drained();

      random_phase(150);
      wait_drained();
      send_idle_pct = 51;
      random_phase(150);
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 51;
      random_phase(150);
      wait_drained();
      send_idle_pct = 29;
      recv_stall_pct = 29;
      random_phase(150);
      wait_drained();

      $display("covered %0d loads and %0d queries, %0d results checked, %0d mismatches",
               loads_sent, queries_sent, results_seen, mismatches);
      $display("phases: no idling, sender idle, receiver stalling, both, long hold-off");
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("tb_prefix_range_min_max_query: done, clean");
      end else begin
         $display("tb_prefix_range_min_max_query: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/prmm_pkg.sv
rtl/prmm_ram.sv
rtl/prmm_engine.sv
rtl/prefix_range_min_max_query.sv
tb/tb_prefix_range_min_max_query.sv
